// ===== rtl/core/sorted_list_merge_defines.svh =====
// Assertion macros used by the checker file slm_checker.sv.
`ifndef SORTED_LIST_MERGE_DEFINES_SVH
`define SORTED_LIST_MERGE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/slm_pkg.sv =====
package slm_pkg;

    localparam int COMMAND_WIDTH = 2;
    localparam int FIELD_WIDTH   = 32;

    localparam logic [COMMAND_WIDTH-1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [COMMAND_WIDTH-1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [COMMAND_WIDTH-1:0] CMD_MERGE         = 2'd2;

    typedef struct packed {
        logic        [COMMAND_WIDTH-1:0] command;
        logic signed [FIELD_WIDTH-1:0]   element;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] merged_value;
        logic                          from_second;
        logic                          last;
        logic                          overflow;
    } t_out_item;

endpackage

// ===== rtl/core/sorted_list_merge.sv =====
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_stall    t_in_item: command, element
// out      out  o_out_valid / i_out_stall  t_out_item: merged_value, from_second, last, overflow
//
// An append transaction writes one entry of its buffer memory, or sets the overflow flag when that buffer is full.
// A merge emits its results in turn, each by two steps: read both heads, then compare and load the output.
// A merge holds o_in_stall high until its last result is loaded; an empty merge never raises it.
// A stall on the output holds the merge in its compare step until the output register frees.
// Reset clears the counts, the overflow flag and the control state; buffer contents are
// never cleared, since only written entries reach the output.
module sorted_list_merge
    import slm_pkg::*;
#(
    parameter int DEPTH         = 32,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // Address width of the buffers, count width holds 0..DEPTH.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Merge sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] r_state, n_state;

    // Buffer memories and their registered read ports.
    logic [ELEMENT_WIDTH-1:0] mem_first  [DEPTH];
    logic [ELEMENT_WIDTH-1:0] mem_second [DEPTH];
    logic [ELEMENT_WIDTH-1:0] r_rd_first, r_rd_second;

    // Fill counts, read pointers and the sticky overflow flag.
    logic [CW-1:0] r_cnt_first, n_cnt_first;
    logic [CW-1:0] r_cnt_second, n_cnt_second;
    logic [CW-1:0] r_ptr_first, n_ptr_first;
    logic [CW-1:0] r_ptr_second, n_ptr_second;
    logic          r_overflow, n_overflow;

    // Output register.
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data, n_out_data;

    logic                        w_in_take;
    logic                        w_slot_free;
    logic                        w_wr_first, w_wr_second;
    logic signed [63:0]          w_elem_ext;
    logic [ELEMENT_WIDTH-1:0]    w_elem;
    logic                        w_first_left, w_second_left;
    logic                        w_take_first;
    logic                        w_last;
    logic signed [ELEMENT_WIDTH-1:0] w_head;
    logic signed [63:0]          w_head_ext;

    // Take the low ELEMENT_WIDTH bits of the sign-extended field.
    assign w_elem_ext = 64'(i_in_data.element);
    assign w_elem     = w_elem_ext[ELEMENT_WIDTH-1:0];

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    assign w_wr_first  = w_in_take && (i_in_data.command == CMD_APPEND_FIRST)
                         && (r_cnt_first < CW'(DEPTH));
    assign w_wr_second = w_in_take && (i_in_data.command == CMD_APPEND_SECOND)
                         && (r_cnt_second < CW'(DEPTH));

    // Compare the two heads; ties go to the second buffer.
    assign w_first_left  = (r_ptr_first  < r_cnt_first);
    assign w_second_left = (r_ptr_second < r_cnt_second);
    assign w_take_first  = w_first_left &&
                           (!w_second_left || ($signed(r_rd_first) < $signed(r_rd_second)));
    assign w_last = w_take_first
        ? ((CW'(r_ptr_first + 1'b1) == r_cnt_first) && !w_second_left)
        : ((CW'(r_ptr_second + 1'b1) == r_cnt_second) && !w_first_left);
    assign w_head     = w_take_first ? r_rd_first : r_rd_second;
    assign w_head_ext = 64'(w_head);

    // Write on append, read the current heads every cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_first) begin
            mem_first[r_cnt_first[AW-1:0]] <= w_elem;
        end
        r_rd_first <= mem_first[r_ptr_first[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_second) begin
            mem_second[r_cnt_second[AW-1:0]] <= w_elem;
        end
        r_rd_second <= mem_second[r_ptr_second[AW-1:0]];
    end

    always_comb begin
        n_state      = r_state;
        n_cnt_first  = r_cnt_first;
        n_cnt_second = r_cnt_second;
        n_ptr_first  = r_ptr_first;
        n_ptr_second = r_ptr_second;
        n_overflow   = r_overflow;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    unique case (i_in_data.command)
                        CMD_APPEND_FIRST: begin
                            if (w_wr_first) begin
                                n_cnt_first = CW'(r_cnt_first + 1'b1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        CMD_APPEND_SECOND: begin
                            if (w_wr_second) begin
                                n_cnt_second = CW'(r_cnt_second + 1'b1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        CMD_MERGE: begin
                            // Start from both heads; an empty merge gives nothing.
                            n_ptr_first  = '0;
                            n_ptr_second = '0;
                            if ((r_cnt_first != '0) || (r_cnt_second != '0)) begin
                                n_state = ST_FETCH;
                            end
                        end
                        default: begin
                            // Drop the unused code.
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // Heads land in the read registers at this edge.
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid             = 1'b1;
                    n_out_data.merged_value = w_head_ext[FIELD_WIDTH-1:0];
                    n_out_data.from_second  = !w_take_first;
                    n_out_data.last         = w_last;
                    n_out_data.overflow     = r_overflow;
                    if (w_take_first) begin
                        n_ptr_first = CW'(r_ptr_first + 1'b1);
                    end else begin
                        n_ptr_second = CW'(r_ptr_second + 1'b1);
                    end
                    if (w_last) begin
                        // Empty both buffers for the next batch.
                        n_cnt_first  = '0;
                        n_cnt_second = '0;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt_first  <= '0;
            r_cnt_second <= '0;
            r_ptr_first  <= '0;
            r_ptr_second <= '0;
            r_overflow   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_first  <= n_cnt_first;
            r_cnt_second <= n_cnt_second;
            r_ptr_first  <= n_ptr_first;
            r_ptr_second <= n_ptr_second;
            r_overflow   <= n_overflow;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/core/slm_checker.sv =====
`include "sorted_list_merge_defines.svh"

module slm_checker
    import slm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input t_in_item  i_in_data,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_data
);

    `SLM_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data), "stalled result changed")

    `SLM_ASSERT_NOW(a_run_busy, i_out_valid && !i_out_data.last, i_in_stall, "input open in the middle of a merge run")

    `SLM_ASSERT_NEXT(a_append_quiet, i_in_valid && !i_in_stall && !i_out_valid && (i_in_data.command == CMD_APPEND_FIRST || i_in_data.command == CMD_APPEND_SECOND), !i_out_valid, "append produced a result")

endmodule

bind sorted_list_merge slm_checker u_slm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
